// ----- design/all_pairs_shortest_path_assert.svh -----
// assertion macros used by the shortest path engine control
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

// same cycle implication
`define APSP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next cycle implication
`define APSP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/apsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package apsp_pkg;

	localparam int MAX_NODES_DEF = 128;
	localparam int ACT_W = 2;
	localparam int NODE_W = 7;
	localparam int WEIGHT_W = 16;
	localparam int DIST_W = 30;
	localparam int CNT_W = 8;

	localparam logic [DIST_W-1:0] INF_DIST = 30'h3f3f3f3f;
	localparam logic [CNT_W-1:0] NODE_COUNT_RST = 8'd128;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_LOAD    = 2'd1,
		ACT_COMPUTE = 2'd2,
		ACT_READ    = 2'd3
	} apsp_action_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_LOAD_A,
		ST_LOAD_B,
		ST_READ_ADDR,
		ST_READ_WAIT,
		ST_COPY,
		ST_COPY_DRAIN,
		ST_PIVOT_ADDR,
		ST_PIVOT_WAIT,
		ST_ROW,
		ST_ROW_DRAIN,
		ST_FINISH
	} apsp_state_t;

	typedef struct packed {
		logic in_rdy;
		logic w_init_we;
		logic w_load_we;
		logic load_swap;
		logic w_rd;
		logic d_rd_piv;
		logic piv_latch;
		logic d_rd_row;
		logic d_rd_item;
		logic res_load;
	} apsp_cmd_t;

	typedef struct packed {
		logic         in_valid;
		apsp_action_t in_act;
		logic         res_busy;
	} apsp_stat_t;

endpackage

`default_nettype wire

// ----- design/apsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface apsp_cfg_if import apsp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] node_count;

	modport source (output valid, output node_count, input ready);
	modport sink (input valid, input node_count, output ready);
endinterface

interface apsp_in_if import apsp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACT_W-1:0]    action;
	logic [NODE_W-1:0]   first_node;
	logic [NODE_W-1:0]   second_node;
	logic [WEIGHT_W-1:0] weight;

	modport source (output valid, output action, output first_node, output second_node,
		output weight, input ready);
	modport sink (input valid, input action, input first_node, input second_node,
		input weight, output ready);
endinterface

interface apsp_out_if import apsp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic              reachable;
	logic              distances_ready;

	modport source (output valid, output distance, output reachable, output distances_ready,
		input ready);
	modport sink (input valid, input distance, input reachable, input distances_ready,
		output ready);
endinterface

`default_nettype wire

// ----- design/apsp_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module apsp_datapath import apsp_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	apsp_in_if.sink                           req,
	apsp_out_if.source                        rsp,
	input  wire apsp_cmd_t                    cmd,
	output      apsp_stat_t                   stat,
	input  wire logic [$clog2(MAX_NODES)-1:0] row_idx,
	input  wire logic [$clog2(MAX_NODES)-1:0] col_idx,
	input  wire logic [$clog2(MAX_NODES)-1:0] via_idx
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int AW = 2 * NW;
	localparam int DEPTH = 1 << AW;

	logic take;

	// item registers
	apsp_action_t        act_q;
	logic [NODE_W-1:0]   a_q;
	logic [NODE_W-1:0]   b_q;
	logic [WEIGHT_W-1:0] wt_q;
	logic                pair_ok;
	logic [NW-1:0]       a_n;
	logic [NW-1:0]       b_n;

	// weight store
	logic [DIST_W-1:0] w_mem [DEPTH];
	logic              w_we;
	logic [AW-1:0]     w_waddr;
	logic [DIST_W-1:0] w_wdata;
	logic [DIST_W-1:0] w_rdata_q;

	// distance store
	logic [DIST_W-1:0] d_mem [DEPTH];
	logic [AW-1:0]     d_raddr_a;
	logic              d_rd_a;
	logic [DIST_W-1:0] rd_a_q;
	logic [DIST_W-1:0] rd_b_q;
	logic [DIST_W-1:0] piv_q;

	// copy and relax pipelines
	logic              copy_v_s1;
	logic [AW-1:0]     copy_addr_s1;
	logic              relax_v_s1;
	logic [AW-1:0]     relax_addr_s1;
	logic [DIST_W:0]   sum_s1;
	logic              better_s1;

	// result
	logic              out_valid_q;
	logic [DIST_W-1:0] dist_q;
	logic              reach_q;
	logic              rdy_out_q;
	logic              rdy_q;
	logic              new_rdy;
	logic [DIST_W-1:0] new_dist;

	assign req.ready = cmd.in_rdy;
	assign take = req.valid & cmd.in_rdy;

	assign stat.in_valid = req.valid;
	assign stat.in_act = apsp_action_t'(req.action);
	assign stat.res_busy = out_valid_q & ~rsp.ready;

	always_ff @(posedge clk) begin
		if (take) begin
			act_q <= apsp_action_t'(req.action);
			a_q <= req.first_node;
			b_q <= req.second_node;
			wt_q <= req.weight;
		end
	end

	assign pair_ok = (32'(a_q) < MAX_NODES) && (32'(b_q) < MAX_NODES);
	assign a_n = NW'(a_q);
	assign b_n = NW'(b_q);

	// weight store ports
	always_comb begin
		w_we = cmd.w_init_we | (cmd.w_load_we & pair_ok);
		if (cmd.w_init_we) begin
			w_waddr = {row_idx, col_idx};
			w_wdata = (row_idx == col_idx) ? '0 : INF_DIST;
		end else begin
			w_waddr = cmd.load_swap ? {b_n, a_n} : {a_n, b_n};
			w_wdata = DIST_W'(wt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[w_waddr] <= w_wdata;
		end
		if (cmd.w_rd) begin
			w_rdata_q <= w_mem[{row_idx, col_idx}];
		end
	end

	// distance store ports
	always_comb begin
		d_rd_a = cmd.d_rd_piv | cmd.d_rd_row | cmd.d_rd_item;
		if (cmd.d_rd_piv) begin
			d_raddr_a = {row_idx, via_idx};
		end else if (cmd.d_rd_row) begin
			d_raddr_a = {via_idx, col_idx};
		end else begin
			d_raddr_a = {a_n, b_n};
		end
	end

	assign sum_s1 = {1'b0, piv_q} + {1'b0, rd_a_q};
	assign better_s1 = relax_v_s1 && (sum_s1 < {1'b0, rd_b_q});

	always_ff @(posedge clk) begin
		if (copy_v_s1) begin
			d_mem[copy_addr_s1] <= w_rdata_q;
		end else if (better_s1) begin
			d_mem[relax_addr_s1] <= sum_s1[DIST_W-1:0];
		end
		if (d_rd_a) begin
			rd_a_q <= d_mem[d_raddr_a];
		end
		if (cmd.d_rd_row) begin
			rd_b_q <= d_mem[{row_idx, col_idx}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.piv_latch) begin
			piv_q <= rd_a_q;
		end
		copy_addr_s1 <= {row_idx, col_idx};
		relax_addr_s1 <= {row_idx, col_idx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_v_s1 <= 1'b0;
			relax_v_s1 <= 1'b0;
		end else begin
			copy_v_s1 <= cmd.w_rd;
			relax_v_s1 <= cmd.d_rd_row;
		end
	end

	// result formation
	always_comb begin
		new_rdy = rdy_q;
		new_dist = '0;
		unique case (act_q) inside
			ACT_CLEAR, ACT_LOAD: begin
				new_rdy = 1'b0;
			end
			ACT_COMPUTE: begin
				new_rdy = 1'b1;
			end
			ACT_READ: begin
				new_dist = pair_ok ? rd_a_q : INF_DIST;
			end
			default: begin
				new_rdy = rdy_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rdy_q <= 1'b0;
		end else begin
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
				rdy_q <= new_rdy;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			dist_q <= new_dist;
			reach_q <= (act_q == ACT_READ) && (new_dist < INF_DIST);
			rdy_out_q <= new_rdy;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.distance = dist_q;
	assign rsp.reachable = reach_q;
	assign rsp.distances_ready = rdy_out_q;

endmodule

`default_nettype wire

// ----- design/apsp_control.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "all_pairs_shortest_path_assert.svh"

module apsp_control import apsp_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	apsp_cfg_if.sink                          cfg,
	input  wire apsp_stat_t                   stat,
	output      apsp_cmd_t                    cmd,
	output      logic [$clog2(MAX_NODES)-1:0] row_idx,
	output      logic [$clog2(MAX_NODES)-1:0] col_idx,
	output      logic [$clog2(MAX_NODES)-1:0] via_idx
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int CNT_RST = (int'(NODE_COUNT_RST) > MAX_NODES) ? MAX_NODES
		: int'(NODE_COUNT_RST);

	apsp_state_t state_q;
	apsp_state_t state_d;

	logic [CW-1:0] cnt_q;
	logic [NW-1:0] row_q;
	logic [NW-1:0] col_q;
	logic [NW-1:0] via_q;
	logic          last_col;
	logic          last_row;
	logic          last_via;
	logic          sweep_last;
	logic          item_taken;
	logic          sweep_rd;
	logic          col_in_range;
	logic          piv_in_range;

	// node count register, clamped on write
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CW'(CNT_RST);
		end else if (cfg.valid) begin
			cnt_q <= (32'(cfg.node_count) > MAX_NODES) ? CW'(MAX_NODES)
				: CW'(cfg.node_count);
		end
	end

	assign last_col = (32'(col_q) == 32'(cnt_q) - 32'd1);
	assign last_row = (32'(row_q) == 32'(cnt_q) - 32'd1);
	assign last_via = (32'(via_q) == 32'(cnt_q) - 32'd1);
	assign sweep_last = (&row_q) && (&col_q);

	assign row_idx = row_q;
	assign col_idx = col_q;
	assign via_idx = via_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			via_q <= '0;
		end else begin
			case (state_q) inside
				ST_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					via_q <= '0;
				end
				ST_INIT, ST_CLEAR: begin
					col_q <= col_q + 1'b1;
					if (&col_q) begin
						row_q <= row_q + 1'b1;
					end
				end
				ST_COPY: begin
					if (last_col) begin
						col_q <= '0;
						row_q <= last_row ? '0 : row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_ROW: begin
					col_q <= last_col ? '0 : col_q + 1'b1;
				end
				ST_ROW_DRAIN: begin
					if (last_row) begin
						row_q <= '0;
						via_q <= via_q + 1'b1;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				default: begin
					row_q <= row_q;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (stat.in_valid) begin
					unique case (stat.in_act)
						ACT_CLEAR:   state_d = ST_CLEAR;
						ACT_LOAD:    state_d = ST_LOAD_A;
						ACT_COMPUTE: state_d = (cnt_q == '0) ? ST_FINISH : ST_COPY;
						ACT_READ:    state_d = ST_READ_ADDR;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (sweep_last) state_d = ST_FINISH;
			end
			ST_LOAD_A:     state_d = ST_LOAD_B;
			ST_LOAD_B:     state_d = ST_FINISH;
			ST_READ_ADDR:  state_d = ST_READ_WAIT;
			ST_READ_WAIT:  state_d = ST_FINISH;
			ST_COPY: begin
				if (last_col && last_row) state_d = ST_COPY_DRAIN;
			end
			ST_COPY_DRAIN: state_d = ST_PIVOT_ADDR;
			ST_PIVOT_ADDR: state_d = ST_PIVOT_WAIT;
			ST_PIVOT_WAIT: state_d = ST_ROW;
			ST_ROW: begin
				if (last_col) state_d = ST_ROW_DRAIN;
			end
			ST_ROW_DRAIN: begin
				state_d = (last_row && last_via) ? ST_FINISH : ST_PIVOT_ADDR;
			end
			ST_FINISH: begin
				if (!stat.res_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:       cmd.in_rdy = 1'b1;
			ST_INIT:       cmd.w_init_we = 1'b1;
			ST_CLEAR:      cmd.w_init_we = 1'b1;
			ST_LOAD_A:     cmd.w_load_we = 1'b1;
			ST_LOAD_B: begin
				cmd.w_load_we = 1'b1;
				cmd.load_swap = 1'b1;
			end
			ST_READ_ADDR:  cmd.d_rd_item = 1'b1;
			ST_COPY:       cmd.w_rd = 1'b1;
			ST_PIVOT_ADDR: cmd.d_rd_piv = 1'b1;
			ST_PIVOT_WAIT: cmd.piv_latch = 1'b1;
			ST_ROW:        cmd.d_rd_row = 1'b1;
			ST_FINISH:     cmd.res_load = !stat.res_busy;
			default:       cmd = '0;
		endcase
	end

	assign item_taken = stat.in_valid && cmd.in_rdy;
	assign sweep_rd = cmd.d_rd_row || cmd.w_rd;
	assign col_in_range = 32'(col_q) < 32'(cnt_q);
	assign piv_in_range = (32'(via_q) < 32'(cnt_q)) && (32'(row_q) < 32'(cnt_q));

	`APSP_ASSERT_IMP(a_no_res_overrun, clk, arst_n, cmd.res_load, !stat.res_busy, "result overrun")
	`APSP_ASSERT_NXT(a_one_item, clk, arst_n, item_taken, !cmd.in_rdy, "second item taken")
	`APSP_ASSERT_IMP(a_col_bound, clk, arst_n, sweep_rd, col_in_range, "column past node count")
	`APSP_ASSERT_IMP(a_via_bound, clk, arst_n, cmd.d_rd_piv, piv_in_range, "pivot past node count")

endmodule

`default_nettype wire

// ----- design/all_pairs_shortest_path.sv -----
// Floyd-Warshall shortest path engine. One item at a time is taken on req and each gives exactly
// one item on rsp; a finished result waits in the rsp register. After reset the weight store is
// swept to infinity/zero diagonal, one entry a cycle, over all (2**clog2(MAX_NODES))**2 entries
// (16384 at 128 nodes) while req is held off; a clear item runs the same sweep. Load makes two
// writes to the single weight port, read does a registered distance read. Compute with n =
// clamped node_count makes a copy of the active weights, then per pivot and per row one pivot
// read plus a stream of one relaxation a cycle through the two read ports of the distance store.
`timescale 1ns / 1ps
`default_nettype none

module all_pairs_shortest_path import apsp_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	apsp_cfg_if.sink   cfg,
	apsp_in_if.sink    req,
	apsp_out_if.source rsp
);

	localparam int NW = $clog2(MAX_NODES);

	apsp_cmd_t     cmd;
	apsp_stat_t    stat;
	logic [NW-1:0] row_idx;
	logic [NW-1:0] col_idx;
	logic [NW-1:0] via_idx;

	apsp_control #(
		.MAX_NODES(MAX_NODES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.stat    (stat),
		.cmd     (cmd),
		.row_idx (row_idx),
		.col_idx (col_idx),
		.via_idx (via_idx)
	);

	apsp_datapath #(
		.MAX_NODES(MAX_NODES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cmd     (cmd),
		.stat    (stat),
		.row_idx (row_idx),
		.col_idx (col_idx),
		.via_idx (via_idx)
	);

endmodule

`default_nettype wire
